>>> hdl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared widths, register indexes, the result bundle and the key code table.
// ----------------------------------------------------------------------------
package kpd_pkg;

   localparam int COLS_W  = 4;
   localparam int ROWS_W  = 4;
   localparam int MASK_W  = 16;
   localparam int ASCII_W = 7;
   localparam int TICK_W  = 16;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_SETTLE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_GAP = 8'd1;

   localparam logic [TICK_W-1:0] ROW_SETTLE_RESET   = 16'd500;
   localparam logic [TICK_W-1:0] DEBOUNCE_GAP_RESET = 16'd15000;

   typedef struct packed {
      logic [ROWS_W-1:0]  row_drive;
      logic               scan_done;
      logic               key_valid;
      logic [ASCII_W-1:0] key_ascii;
      logic [MASK_W-1:0]  new_press_mask;
      logic [MASK_W-1:0]  stable_mask;
   } kpd_result_type;

   function automatic logic [ASCII_W-1:0] kpd_key_code(input logic [3:0] key);
      logic [ASCII_W-1:0] code;
      case (key)
         4'd0:    code = 7'h2A; // *
         4'd1:    code = 7'h30; // 0
         4'd2:    code = 7'h23; // #
         4'd3:    code = 7'h44; // D
         4'd4:    code = 7'h37; // 7
         4'd5:    code = 7'h38; // 8
         4'd6:    code = 7'h39; // 9
         4'd7:    code = 7'h43; // C
         4'd8:    code = 7'h34; // 4
         4'd9:    code = 7'h35; // 5
         4'd10:   code = 7'h36; // 6
         4'd11:   code = 7'h42; // B
         4'd12:   code = 7'h31; // 1
         4'd13:   code = 7'h32; // 2
         4'd14:   code = 7'h33; // 3
         default: code = 7'h41; // A
      endcase
      return code;
   endfunction

endpackage

>>> hdl/kpd_key_encode.sv
// ----------------------------------------------------------------------------
// Keypad key encoder
// Picks the lowest set bit of a key mask and returns its ASCII code, or zero.
// ----------------------------------------------------------------------------
module kpd_key_encode (
   input  logic [kpd_pkg::MASK_W-1:0]  key_mask,
   output logic [kpd_pkg::ASCII_W-1:0] key_ascii
);
   import kpd_pkg::*;

   logic [3:0] key_idx;
   logic       key_found;

   always_comb begin
      key_idx   = '0;
      key_found = 1'b0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (key_mask[i]) begin
            key_idx   = 4'(i);
            key_found = 1'b1;
         end
      end
      key_ascii = key_found ? kpd_key_code(key_idx) : '0;
   end

endmodule

>>> hdl/kpd_scan_core.sv
// ----------------------------------------------------------------------------
// Keypad scan core
// Holds the scan sequencer state and computes one tick's result and update.
// ----------------------------------------------------------------------------
module kpd_scan_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [kpd_pkg::COLS_W-1:0]    cols,
   input  logic [kpd_pkg::TICK_W-1:0]    row_settle,
   input  logic [kpd_pkg::TICK_W-1:0]    debounce_gap,
   output kpd_pkg::kpd_result_type       result
);
   import kpd_pkg::*;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_GAP    = 2'd1;
   localparam logic [1:0] PHASE_SECOND = 2'd2;
   localparam logic [1:0] ROW_LAST     = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        row_ff, row_in;
   logic [TICK_W-1:0] wait_ff, wait_in;
   logic [MASK_W-1:0] first_ff, first_in;
   logic [MASK_W-1:0] second_ff, second_in;
   logic [MASK_W-1:0] held_ff, held_in;

   logic [TICK_W-1:0] gap_count;
   logic              second_scan;
   logic [3:0]        nib_base;
   logic [MASK_W-1:0] held_now;
   logic [MASK_W-1:0] fresh;
   logic              done;
   logic [ASCII_W-1:0] fresh_ascii;

   kpd_key_encode u_encode (
      .key_mask  (fresh),
      .key_ascii (fresh_ascii)
   );

   always_comb begin
      phase_in    = phase_ff;
      row_in      = row_ff;
      wait_in     = wait_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      held_in     = held_ff;
      fresh       = '0;
      done        = 1'b0;
      gap_count   = wait_ff;
      second_scan = 1'b0;
      nib_base    = {~row_ff, 2'b00};
      held_now    = '0;
      result.row_drive = '0;
      case (phase_ff)
         PHASE_GAP: begin
            if (wait_ff < debounce_gap) begin
               gap_count = wait_ff + 1'b1;
            end
            if (gap_count >= debounce_gap) begin
               phase_in = PHASE_SECOND;
               row_in   = '0;
               wait_in  = '0;
            end else begin
               wait_in = gap_count;
            end
         end
         default: begin
            second_scan = (phase_ff == PHASE_SECOND);
            phase_in    = second_scan ? PHASE_SECOND : PHASE_FIRST;
            result.row_drive = ROWS_W'(1) << row_ff;
            if (wait_ff >= row_settle) begin
               wait_in = '0;
               if (second_scan) begin
                  second_in[nib_base +: COLS_W] = cols;
               end else begin
                  first_in[nib_base +: COLS_W] = cols;
               end
               if (row_ff == ROW_LAST) begin
                  row_in = '0;
                  if (second_scan) begin
                     held_now = first_ff & second_in;
                     fresh    = held_now & ~held_ff;
                     held_in  = held_now;
                     done     = 1'b1;
                     phase_in = PHASE_FIRST;
                  end else begin
                     phase_in = (debounce_gap == '0) ? PHASE_SECOND : PHASE_GAP;
                  end
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
      endcase
      result.scan_done      = done;
      result.key_valid      = done & (|fresh);
      result.key_ascii      = fresh_ascii;
      result.new_press_mask = fresh;
      result.stable_mask    = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_FIRST;
         row_ff    <= '0;
         wait_ff   <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         held_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         row_ff    <= row_in;
         wait_ff   <= wait_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         held_ff   <= held_in;
      end
   end

endmodule

>>> hdl/keypad_scan_debounce_edge_encoder.sv
// ----------------------------------------------------------------------------
// 4x4 keypad scanner with debounce and new-press encoding
// Scans rows per tick request, double-scans to debounce and reports new keys.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake         Contents
//  req_     in         valid / stall     sampled column lines, one per tick
//  rsp_     out        valid / stall     row drive, scan status, key masks
//  csr_     in         valid / ready     register index and write data
//
// A request passes through the input register, then the result register,
// and one is taken every cycle unless a stalled result holds and backs up
// the input register. Reset clears the scan state, key history and valid
// flags, and sets the timing CSRs to their power-up values.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_edge_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kpd_pkg::COLS_W-1:0]      req_column_lines,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kpd_pkg::ROWS_W-1:0]      rsp_row_drive,
   output logic                            rsp_scan_done,
   output logic                            rsp_key_valid,
   output logic [kpd_pkg::ASCII_W-1:0]     rsp_key_ascii,
   output logic [kpd_pkg::MASK_W-1:0]      rsp_new_press_mask,
   output logic [kpd_pkg::MASK_W-1:0]      rsp_stable_mask,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kpd_pkg::TICK_W-1:0]      csr_wdata
);
   import kpd_pkg::*;

   logic               in_valid_ff;
   logic [COLS_W-1:0]  in_cols_ff;
   logic               out_valid_ff;
   kpd_result_type     out_ff;
   kpd_result_type     step_result;
   logic [TICK_W-1:0]  settle_ff;
   logic [TICK_W-1:0]  gap_ff;
   logic               advance;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign csr_ready = 1'b1;

   kpd_scan_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cols         (in_cols_ff),
      .row_settle   (settle_ff),
      .debounce_gap (gap_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         settle_ff    <= ROW_SETTLE_RESET;
         gap_ff       <= DEBOUNCE_GAP_RESET;
      end else begin
         if (~req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_SETTLE:   settle_ff <= csr_wdata;
               CSR_DEBOUNCE_GAP: gap_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cols_ff <= req_column_lines;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_row_drive      = out_ff.row_drive;
   assign rsp_scan_done      = out_ff.scan_done;
   assign rsp_key_valid      = out_ff.key_valid;
   assign rsp_key_ascii      = out_ff.key_ascii;
   assign rsp_new_press_mask = out_ff.new_press_mask;
   assign rsp_stable_mask    = out_ff.stable_mask;

endmodule
